>>> hdl/vpi_pkg.sv
package vpi_pkg;

   localparam int DATA_W = 32;
   localparam int WIDE_W = 64;
   localparam int PID_W = 10;
   localparam int AXES = 3;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DT_SQUARED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DT = 1'b1;

   localparam logic [DATA_W-1:0] DT_SQUARED_RESET = 32'd429497;
   localparam logic [DATA_W-1:0] INV_DT_RESET = 32'd6553600;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic [DATA_W-1:0] ufix_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
      logic en5;
      logic en6;
      logic en7;
      logic s1_step;
   } vpi_ctl_type;

endpackage

>>> hdl/verlet_particle_integrator.sv
// Pipeline: 8 stages in all, 0 to 7; rsp_valid is the valid bit of stage 7.
// Throughput: one beat per cycle while rsp_stall is low; a step of a particle
// still held in compute stages 1 to 3 waits in stage 0 until that beat writes back.
// Reset (synchronous, active high) clears the stage valid bits and sets
// dt_squared and inv_dt to their defaults; particle memory is not cleared.
module verlet_particle_integrator #(
   parameter int PARTICLES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [vpi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vpi_pkg::DATA_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [vpi_pkg::PID_W-1:0]            req_particle,
   input  vpi_pkg::fix_type                     req_load_x,
   input  vpi_pkg::fix_type                     req_load_y,
   input  vpi_pkg::fix_type                     req_load_z,
   input  vpi_pkg::fix_type                     req_force_x,
   input  vpi_pkg::fix_type                     req_force_y,
   input  vpi_pkg::fix_type                     req_force_z,
   input  vpi_pkg::ufix_type                    req_inv_mass,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vpi_pkg::PID_W-1:0]            rsp_out_particle,
   output vpi_pkg::fix_type                     rsp_pos_x,
   output vpi_pkg::fix_type                     rsp_pos_y,
   output vpi_pkg::fix_type                     rsp_pos_z,
   output vpi_pkg::fix_type                     rsp_vel_x,
   output vpi_pkg::fix_type                     rsp_vel_y,
   output vpi_pkg::fix_type                     rsp_vel_z
);
   import vpi_pkg::*;

   localparam int IDX_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int STAGES = 8;
   localparam int WB = 3;

   typedef struct packed {
      logic [AXES-1:0][DATA_W-1:0] cur;
      logic [AXES-1:0][DATA_W-1:0] prev;
   } entry_type;

   ufix_type dt_sq_ff, inv_dt_ff;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   ready;
   logic              hazard;

   logic [PID_W-1:0]  pid_ff [STAGES];
   logic [IDX_W-1:0]  idx_ff [WB+1];
   logic [IDX_W-1:0]  idx_in;
   logic [PID_W-1:0]  mod_chain [PID_W+1];
   logic              func0_ff;
   logic              step1_ff;

   fix_type  force_ff [AXES];
   fix_type  load_ff [AXES];
   fix_type  force_in [AXES];
   fix_type  load_in [AXES];
   ufix_type inv_mass_ff;

   entry_type entry_mem_ff [PARTICLES];
   entry_type rd_ff;
   entry_type wr_entry;
   logic      wr_en;

   fix_type wr_cur [AXES];
   fix_type wr_prev [AXES];
   fix_type pos [AXES];
   fix_type vel [AXES];

   vpi_ctl_type ctl;

   // fold the particle field onto the memory depth
   assign mod_chain[PID_W] = req_particle;
   for (genvar k = PID_W - 1; k >= 0; k--) begin : g_mod
      localparam int SUB = PARTICLES << k;
      if (SUB < (1 << PID_W)) begin : g_sub
         assign mod_chain[k] = (mod_chain[k+1] >= PID_W'(SUB)) ?
                               mod_chain[k+1] - PID_W'(SUB) : mod_chain[k+1];
      end else begin : g_pass
         assign mod_chain[k] = mod_chain[k+1];
      end
   end
   assign idx_in = IDX_W'(mod_chain[0]);

   assign force_in[0] = req_force_x;
   assign force_in[1] = req_force_y;
   assign force_in[2] = req_force_z;
   assign load_in[0] = req_load_x;
   assign load_in[1] = req_load_y;
   assign load_in[2] = req_load_z;

   // hold a step while an older beat for the same particle has not written back
   always_comb begin
      hazard = 1'b0;
      for (int k = 1; k <= WB; k++) begin
         if (valid_ff[k] && (idx_ff[k] == idx_ff[0])) begin
            hazard = 1'b1;
         end
      end
      hazard = hazard && valid_ff[0] && (func0_ff == FUNC_STEP);
   end

   always_comb begin
      ready[STAGES] = !rsp_stall;
      for (int k = STAGES - 1; k >= 1; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      ready[0] = !valid_ff[0] || (ready[1] && !hazard);
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      valid_in[1] = ready[1] ? (valid_ff[0] && !hazard) : valid_ff[1];
      for (int k = 2; k < STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dt_sq_ff <= DT_SQUARED_RESET;
         inv_dt_ff <= INV_DT_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_DT_SQUARED: dt_sq_ff <= csr_wdata;
               CSR_INV_DT:     inv_dt_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         func0_ff <= req_func;
         pid_ff[0] <= req_particle;
         idx_ff[0] <= idx_in;
         inv_mass_ff <= req_inv_mass;
         for (int a = 0; a < AXES; a++) begin
            force_ff[a] <= force_in[a];
            load_ff[a] <= load_in[a];
         end
      end
      if (ready[1]) begin
         step1_ff <= (func0_ff == FUNC_STEP);
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ready[k]) begin
            pid_ff[k] <= pid_ff[k-1];
         end
      end
      for (int k = 1; k <= WB; k++) begin
         if (ready[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
   end

   // write back as the beat leaves stage 3
   always_comb begin
      wr_en = valid_ff[WB] && ready[WB+1];
      for (int a = 0; a < AXES; a++) begin
         wr_entry.cur[a] = wr_cur[a];
         wr_entry.prev[a] = wr_prev[a];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[idx_ff[WB]] <= wr_entry;
      end
      if (ready[1]) begin
         rd_ff <= entry_mem_ff[idx_ff[0]];
      end
   end

   always_comb begin
      ctl.en1 = ready[1];
      ctl.en2 = ready[2];
      ctl.en3 = ready[3];
      ctl.en4 = ready[4];
      ctl.en5 = ready[5];
      ctl.en6 = ready[6];
      ctl.en7 = ready[7];
      ctl.s1_step = step1_ff;
   end

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      vpi_axis u_axis (
         .clock      (clock),
         .ctl        (ctl),
         .dt_squared (dt_sq_ff),
         .inv_dt     (inv_dt_ff),
         .inv_mass   (inv_mass_ff),
         .force_val  (force_ff[a]),
         .load_val   (load_ff[a]),
         .cur_val    (rd_ff.cur[a]),
         .prev_val   (rd_ff.prev[a]),
         .wr_cur     (wr_cur[a]),
         .wr_prev    (wr_prev[a]),
         .pos        (pos[a]),
         .vel        (vel[a])
      );
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_out_particle = pid_ff[STAGES-1];
   assign rsp_pos_x = pos[0];
   assign rsp_pos_y = pos[1];
   assign rsp_pos_z = pos[2];
   assign rsp_vel_x = vel[0];
   assign rsp_vel_y = vel[1];
   assign rsp_vel_z = vel[2];

   a_no_raw_s2: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && step1_ff && valid_ff[2] |-> idx_ff[2] != idx_ff[1])
      else $error("step in stage 1 shares a particle with stage 2");

   a_no_raw_s3: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && step1_ff && valid_ff[3] |-> idx_ff[3] != idx_ff[1])
      else $error("step in stage 1 shares a particle with stage 3");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0] && pid_ff[0] == $past(req_particle))
      else $error("accepted beat missing from stage 0");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && rsp_stall && valid_ff[STAGES-2] |=> valid_ff[STAGES-2])
      else $error("beat dropped behind a stalled output");

endmodule

>>> hdl/vpi_axis.sv
module vpi_axis (
   input  logic                 clock,
   input  vpi_pkg::vpi_ctl_type ctl,
   input  vpi_pkg::ufix_type    dt_squared,
   input  vpi_pkg::ufix_type    inv_dt,
   input  vpi_pkg::ufix_type    inv_mass,
   input  vpi_pkg::fix_type     force_val,
   input  vpi_pkg::fix_type     load_val,
   input  vpi_pkg::fix_type     cur_val,
   input  vpi_pkg::fix_type     prev_val,
   output vpi_pkg::fix_type     wr_cur,
   output vpi_pkg::fix_type     wr_prev,
   output vpi_pkg::fix_type     pos,
   output vpi_pkg::fix_type     vel
);
   import vpi_pkg::*;

   localparam int BASE_W = DATA_W + 2;
   localparam int TERM_W = 48;
   localparam int SUM_W = 50;
   localparam int DIFF_W = DATA_W + 1;
   localparam int VSUM_W = WIDE_W + 1;
   localparam int SHIFT = 16;

   // stage 1
   logic              fneg1_ff, fneg1_in;
   logic [WIDE_W-1:0] p1_ff, p1_in;
   fix_type           load1_ff;
   ufix_type          fmag;

   // stage 2
   logic                     fneg2_ff;
   logic [WIDE_W-1:0]        prodh2_ff, prodh2_in;
   logic [DATA_W-1:0]        prodl2_ff, prodl2_in;
   logic [WIDE_W-1:0]        prodl_full;
   logic signed [BASE_W-1:0] base2_ff, base2_in;
   fix_type                  c2_ff, c2_in;

   // stage 3
   logic                     fneg3_ff;
   logic [WIDE_W-1:0]        sum64;
   logic [TERM_W-1:0]        r3_ff, r3_in;
   logic signed [BASE_W-1:0] base3_ff;
   fix_type                  c3_ff;
   logic signed [TERM_W:0]   term_mag, term;
   logic signed [SUM_W-1:0]  npos_sum;
   fix_type                  npos;

   // stage 4..7
   fix_type                  pos4_ff, c4_ff;
   logic signed [DIFF_W-1:0] diff;
   logic                     dneg5_ff, dneg5_in;
   logic [DIFF_W-1:0]        dmag5_ff, dmag5_in;
   fix_type                  pos5_ff;
   logic [WIDE_W-1:0]        m6_ff, m6_in;
   logic                     dhi6_ff, dneg6_ff;
   fix_type                  pos6_ff;
   logic [VSUM_W-1:0]        vsum;
   logic [VSUM_W-SHIFT-1:0]  vmag;
   fix_type                  vel7_ff, vel7_in, pos7_ff;

   always_comb begin
      fmag = force_val[DATA_W-1] ? ufix_type'(-force_val) : ufix_type'(force_val);
      fneg1_in = force_val[DATA_W-1];
      p1_in = WIDE_W'(fmag) * WIDE_W'(inv_mass);
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         fneg1_ff <= fneg1_in;
         p1_ff <= p1_in;
         load1_ff <= load_val;
      end
   end

   // zero the force term on a load so the load value passes straight through
   always_comb begin
      prodl_full = WIDE_W'(p1_ff[DATA_W-1:0]) * WIDE_W'(dt_squared);
      if (ctl.s1_step) begin
         prodh2_in = WIDE_W'(p1_ff[WIDE_W-1:DATA_W]) * WIDE_W'(dt_squared);
         prodl2_in = prodl_full[WIDE_W-1:DATA_W];
         base2_in = (BASE_W'(cur_val) <<< 1) - BASE_W'(prev_val);
         c2_in = cur_val;
      end else begin
         prodh2_in = '0;
         prodl2_in = '0;
         base2_in = BASE_W'(load1_ff);
         c2_in = load1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         fneg2_ff <= fneg1_ff;
         prodh2_ff <= prodh2_in;
         prodl2_ff <= prodl2_in;
         base2_ff <= base2_in;
         c2_ff <= c2_in;
      end
   end

   always_comb begin
      sum64 = prodh2_ff + WIDE_W'(prodl2_ff);
      r3_in = sum64[WIDE_W-1:SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         fneg3_ff <= fneg2_ff;
         r3_ff <= r3_in;
         base3_ff <= base2_ff;
         c3_ff <= c2_ff;
      end
   end

   always_comb begin
      term_mag = {1'b0, r3_ff};
      term = fneg3_ff ? -term_mag : term_mag;
      npos_sum = SUM_W'(base3_ff) + SUM_W'(term);
      if (!npos_sum[SUM_W-1] && (|npos_sum[SUM_W-2:DATA_W-1])) begin
         npos = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (npos_sum[SUM_W-1] && !(&npos_sum[SUM_W-2:DATA_W-1])) begin
         npos = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         npos = npos_sum[DATA_W-1:0];
      end
   end

   assign wr_cur = npos;
   assign wr_prev = c3_ff;

   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         pos4_ff <= npos;
         c4_ff <= c3_ff;
      end
   end

   always_comb begin
      diff = DIFF_W'(pos4_ff) - DIFF_W'(c4_ff);
      dneg5_in = diff[DIFF_W-1];
      dmag5_in = dneg5_in ? DIFF_W'(-diff) : DIFF_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en5) begin
         dneg5_ff <= dneg5_in;
         dmag5_ff <= dmag5_in;
         pos5_ff <= pos4_ff;
      end
   end

   assign m6_in = WIDE_W'(dmag5_ff[DATA_W-1:0]) * WIDE_W'(inv_dt);

   always_ff @(posedge clock) begin
      if (ctl.en6) begin
         m6_ff <= m6_in;
         dhi6_ff <= dmag5_ff[DIFF_W-1];
         dneg6_ff <= dneg5_ff;
         pos6_ff <= pos5_ff;
      end
   end

   always_comb begin
      vsum = {1'b0, m6_ff} + (dhi6_ff ? {1'b0, inv_dt, {DATA_W{1'b0}}} : VSUM_W'(0));
      vmag = vsum[VSUM_W-1:SHIFT];
      if (!dneg6_ff) begin
         if (|vmag[VSUM_W-SHIFT-1:DATA_W-1]) begin
            vel7_in = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            vel7_in = vmag[DATA_W-1:0];
         end
      end else begin
         if ((|vmag[VSUM_W-SHIFT-1:DATA_W]) ||
             (vmag[DATA_W-1] && (|vmag[DATA_W-2:0]))) begin
            vel7_in = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            vel7_in = -fix_type'(vmag[DATA_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en7) begin
         vel7_ff <= vel7_in;
         pos7_ff <= pos6_ff;
      end
   end

   assign pos = pos7_ff;
   assign vel = vel7_ff;

endmodule

>>> tb/sv/verlet_step_checker.sv
module verlet_step_checker #(
   parameter int PARTICLES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [vpi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vpi_pkg::DATA_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_func,
   input  logic [vpi_pkg::PID_W-1:0]      req_particle,
   input  vpi_pkg::fix_type               req_load_x,
   input  vpi_pkg::fix_type               req_load_y,
   input  vpi_pkg::fix_type               req_load_z,
   input  vpi_pkg::fix_type               req_force_x,
   input  vpi_pkg::fix_type               req_force_y,
   input  vpi_pkg::fix_type               req_force_z,
   input  vpi_pkg::ufix_type              req_inv_mass,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [vpi_pkg::PID_W-1:0]      rsp_out_particle,
   input  vpi_pkg::fix_type               rsp_pos_x,
   input  vpi_pkg::fix_type               rsp_pos_y,
   input  vpi_pkg::fix_type               rsp_pos_z,
   input  vpi_pkg::fix_type               rsp_vel_x,
   input  vpi_pkg::fix_type               rsp_vel_y,
   input  vpi_pkg::fix_type               rsp_vel_z,
   output int                             mismatches,
   output int                             outstanding,
   output int                             compared
);
   import vpi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam byte AXIS_X = "x";

   typedef struct packed {
      logic [PID_W-1:0]             pid;
      logic [AXES-1:0][DATA_W-1:0]  pos;
      logic [AXES-1:0][DATA_W-1:0]  vel;
   } step_result_type;

   ufix_type dt_sq = DT_SQUARED_RESET;
   ufix_type inv_dt_q = INV_DT_RESET;
   logic [DATA_W-1:0] cur_pos [0:AXES-1][0:PARTICLES-1];
   logic [DATA_W-1:0] prev_pos [0:AXES-1][0:PARTICLES-1];
   step_result_type due_positions [$];

   wire [AXES-1:0][DATA_W-1:0] load_vec = {req_load_z, req_load_y, req_load_x};
   wire [AXES-1:0][DATA_W-1:0] force_vec = {req_force_z, req_force_y, req_force_x};

   function automatic void advance_axis(input fix_type cur, input fix_type prev,
                                        input fix_type frc, input ufix_type imass,
                                        output fix_type npos, output fix_type vel);
      logic [DATA_W-1:0] fmag;
      logic [127:0] wide;
      logic [127:0] vq;
      logic [63:0] dmag;
      longint term;
      longint sum;
      longint d;
      fmag = (frc < 0) ? -frc : frc;
      wide = 128'(fmag) * 128'(imass) * 128'(dt_sq);
      term = longint'(wide[95:48]);
      if (frc < 0) term = -term;
      sum = 2 * longint'(cur) - longint'(prev) + term;
      if (sum > 64'sd2147483647) npos = fix_type'(32'h7FFF_FFFF);
      else if (sum < -64'sd2147483648) npos = fix_type'(32'h8000_0000);
      else npos = fix_type'(sum);
      d = longint'(npos) - longint'(cur);
      dmag = (d < 0) ? -d : d;
      vq = (128'(dmag) * 128'(inv_dt_q)) >> 16;
      if (d < 0) begin
         if (vq > 128'h8000_0000) vel = fix_type'(32'h8000_0000);
         else vel = fix_type'(-longint'(vq));
      end else begin
         if (vq > 128'h7FFF_FFFF) vel = fix_type'(32'h7FFF_FFFF);
         else vel = fix_type'(vq[31:0]);
      end
   endfunction

   always @(posedge clock) begin
      step_result_type want;
      step_result_type got;
      int idx;
      fix_type cur_v;
      fix_type prev_v;
      fix_type new_v;
      fix_type vel_v;
      if (reset) begin
         dt_sq = DT_SQUARED_RESET;
         inv_dt_q = INV_DT_RESET;
         due_positions.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_DT_SQUARED) dt_sq = csr_wdata;
            else if (csr_index == CSR_INV_DT) inv_dt_q = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_positions.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat, expected none, actual particle %0d",
                        $time, rsp_out_particle);
            end else begin
               want = due_positions.pop_front();
               got.pid = rsp_out_particle;
               got.pos = {rsp_pos_z, rsp_pos_y, rsp_pos_x};
               got.vel = {rsp_vel_z, rsp_vel_y, rsp_vel_x};
               if (got.pid !== want.pid) begin
                  mismatches++;
                  $display("%0t: out_particle expected %0d actual %0d",
                           $time, want.pid, got.pid);
               end
               for (int a = 0; a < AXES; a++) begin
                  if (got.pos[a] !== want.pos[a]) begin
                     mismatches++;
                     $display("%0t: particle %0d pos_%c expected %h actual %h", $time,
                              want.pid, AXIS_X + a, want.pos[a], got.pos[a]);
                  end
                  if (got.vel[a] !== want.vel[a]) begin
                     mismatches++;
                     $display("%0t: particle %0d vel_%c expected %h actual %h", $time,
                              want.pid, AXIS_X + a, want.vel[a], got.vel[a]);
                  end
               end
               compared++;
            end
         end
         if (req_valid && !req_stall) begin
            idx = int'(req_particle) % PARTICLES;
            want.pid = req_particle;
            for (int a = 0; a < AXES; a++) begin
               if (req_func == FUNC_LOAD) begin
                  cur_pos[a][idx] = load_vec[a];
                  prev_pos[a][idx] = load_vec[a];
                  want.pos[a] = load_vec[a];
                  want.vel[a] = '0;
               end else begin
                  cur_v = fix_type'(cur_pos[a][idx]);
                  prev_v = fix_type'(prev_pos[a][idx]);
                  advance_axis(cur_v, prev_v, fix_type'(force_vec[a]), req_inv_mass,
                               new_v, vel_v);
                  prev_pos[a][idx] = cur_v;
                  cur_pos[a][idx] = new_v;
                  want.pos[a] = new_v;
                  want.vel[a] = vel_v;
               end
            end
            due_positions.push_back(want);
         end
      end
      outstanding = due_positions.size();
   end

endmodule

>>> tb/sv/tb_verlet_particle_integrator.sv
module tb_verlet_particle_integrator;

   import vpi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARTICLES = 1024;
   localparam int PHASES = 6;
   localparam int BEATS_PER_PHASE = 306;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam fix_type FIX_MAX = fix_type'(32'h7FFF_FFFF);
   localparam fix_type FIX_MIN = fix_type'(32'h8000_0000);
   localparam fix_type FIX_ONE = fix_type'(32'h0001_0000);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DT_SQUARED;
   logic [DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FUNC_LOAD;
   logic [PID_W-1:0] req_particle = '0;
   fix_type req_load_x = '0;
   fix_type req_load_y = '0;
   fix_type req_load_z = '0;
   fix_type req_force_x = '0;
   fix_type req_force_y = '0;
   fix_type req_force_z = '0;
   ufix_type req_inv_mass = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PID_W-1:0] rsp_out_particle;
   fix_type rsp_pos_x;
   fix_type rsp_pos_y;
   fix_type rsp_pos_z;
   fix_type rsp_vel_x;
   fix_type rsp_vel_y;
   fix_type rsp_vel_z;

   int mismatches;
   int outstanding;
   int compared;
   int cycle_count = 0;
   int n_loads = 0;
   int n_steps = 0;
   int n_settings = 0;
   bit calm = 1'b0;
   bit loaded [0:PARTICLES-1];
   int stall_hold = 0;
   bit stall_on = 1'b0;

   verlet_particle_integrator #(
      .PARTICLES(PARTICLES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_particle(req_particle),
      .req_load_x(req_load_x),
      .req_load_y(req_load_y),
      .req_load_z(req_load_z),
      .req_force_x(req_force_x),
      .req_force_y(req_force_y),
      .req_force_z(req_force_z),
      .req_inv_mass(req_inv_mass),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_particle(rsp_out_particle),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z)
   );

   verlet_step_checker #(
      .PARTICLES(PARTICLES)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_particle(req_particle),
      .req_load_x(req_load_x),
      .req_load_y(req_load_y),
      .req_load_z(req_load_z),
      .req_force_x(req_force_x),
      .req_force_y(req_force_y),
      .req_force_z(req_force_z),
      .req_inv_mass(req_inv_mass),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_particle(rsp_out_particle),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .compared(compared)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** verlet_particle_integrator: FAILED **");
         $finish;
      end
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int stall_cycles();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic fix_type pick_fix();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return FIX_MAX;
      if (r == 1) return FIX_MIN;
      if (r == 2) return '0;
      if (r < 5) return fix_type'($urandom);
      if (r < 8) return fix_type'(int'($urandom_range(0, 2097152)) - 1048576);
      return fix_type'(int'($urandom_range(0, 33554432)) - 16777216);
   endfunction

   function automatic ufix_type pick_mass();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 32'hFFFF_FFFF;
      if (r < 4) return $urandom;
      return $urandom_range(4096, 1048576);
   endfunction

   // hold the response side off in runs of random length
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_on = !stall_on;
         stall_hold = stall_on ? stall_cycles() : $urandom_range(1, 12);
      end
      stall_hold--;
      rsp_stall <= stall_on && !calm;
   end

   task automatic drive_beat(input logic func, input logic [PID_W-1:0] pid,
                             input fix_type a, input fix_type b, input fix_type c,
                             input ufix_type im);
      int gap;
      gap = calm ? 0 : gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_particle <= pid;
      if (func == FUNC_LOAD) begin
         req_load_x <= a;
         req_load_y <= b;
         req_load_z <= c;
         req_force_x <= fix_type'($urandom);
         req_force_y <= fix_type'($urandom);
         req_force_z <= fix_type'($urandom);
         req_inv_mass <= $urandom;
         loaded[pid] = 1'b1;
         n_loads++;
      end else begin
         req_load_x <= fix_type'($urandom);
         req_load_y <= fix_type'($urandom);
         req_load_z <= fix_type'($urandom);
         req_force_x <= a;
         req_force_y <= b;
         req_force_z <= c;
         req_inv_mass <= im;
         n_steps++;
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input ufix_type dt, input ufix_type idt);
      csr_write <= 1'b1;
      csr_index <= CSR_DT_SQUARED;
      csr_wdata <= dt;
      @(negedge clock);
      csr_index <= CSR_INV_DT;
      csr_wdata <= idt;
      @(negedge clock);
      csr_write <= 1'b0;
      n_settings++;
   endtask

   initial begin
      ufix_type dt_set [PHASES];
      ufix_type idt_set [PHASES];
      logic [PID_W-1:0] pid;
      logic func;
      int r;
      dt_set[0] = DT_SQUARED_RESET;
      idt_set[0] = INV_DT_RESET;
      dt_set[1] = 32'hFFFF_FFFF;
      idt_set[1] = 32'hFFFF_FFFF;
      dt_set[2] = '0;
      idt_set[2] = '0;
      dt_set[3] = $urandom_range(1, 1048576);
      idt_set[3] = 32'h0001_0000;
      dt_set[4] = $urandom;
      idt_set[4] = $urandom;
      dt_set[5] = DT_SQUARED_RESET;
      idt_set[5] = INV_DT_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      drive_beat(FUNC_LOAD, 10'd0, FIX_MAX, FIX_MIN, '0, '0);
      drive_beat(FUNC_LOAD, 10'd1023, FIX_MIN, FIX_MAX, fix_type'(1), '0);
      drive_beat(FUNC_LOAD, 10'd512, FIX_ONE, -FIX_ONE, '0, '0);
      drive_beat(FUNC_STEP, 10'd0, FIX_MAX, FIX_MIN, '0, 32'hFFFF_FFFF);
      drive_beat(FUNC_STEP, 10'd0, '0, '0, '0, '0);
      drive_beat(FUNC_STEP, 10'd0, FIX_MIN, FIX_MAX, FIX_MAX, 32'hFFFF_FFFF);
      drive_beat(FUNC_STEP, 10'd1023, FIX_MIN, FIX_MAX, fix_type'(1), 32'd1);
      drive_beat(FUNC_STEP, 10'd1023, fix_type'(-1), fix_type'(1), '0, 32'h0001_0000);
      drive_beat(FUNC_STEP, 10'd512, '0, '0, '0, 32'h0001_0000);
      drive_beat(FUNC_STEP, 10'd512, FIX_ONE, -FIX_ONE, FIX_MAX, 32'hFFFF_FFFF);
      drive_beat(FUNC_LOAD, 10'd512, pick_fix(), pick_fix(), pick_fix(), pick_mass());
      drive_beat(FUNC_STEP, 10'd512, pick_fix(), pick_fix(), pick_fix(), pick_mass());
      drive_beat(FUNC_STEP, 10'd512, pick_fix(), pick_fix(), pick_fix(), pick_mass());
      drive_beat(FUNC_LOAD, 10'd7, FIX_MIN, FIX_MIN, FIX_MIN, '0);
      drive_beat(FUNC_STEP, 10'd7, FIX_MIN, FIX_MIN, FIX_MIN, 32'hFFFF_FFFF);
      drive_beat(FUNC_LOAD, 10'd1, FIX_MAX, FIX_MAX, FIX_MAX, '0);
      drive_beat(FUNC_STEP, 10'd1, FIX_MAX, FIX_MAX, FIX_MAX, 32'hFFFF_FFFF);
      drive_beat(FUNC_STEP, 10'd1, FIX_MIN, FIX_MIN, FIX_MIN, 32'hFFFF_FFFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            drain_pipeline();
            apply_setting(dt_set[ph], idt_set[ph]);
         end
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) pid = PID_W'($urandom_range(0, 7));
            else if (r < 50) pid = 10'd0;
            else if (r < 55) pid = 10'd1023;
            else pid = PID_W'($urandom_range(0, PARTICLES - 1));
            func = (loaded[pid] && $urandom_range(0, 99) < 78) ? FUNC_STEP : FUNC_LOAD;
            drive_beat(func, pid, pick_fix(), pick_fix(), pick_fix(), pick_mass());
         end
      end
      drain_pipeline();

      $display("covered %0d beats: %0d loads, %0d steps, %0d register settings",
               n_loads + n_steps, n_loads, n_steps, n_settings);
      $display("compared %0d results, %0d mismatches, %0d left waiting",
               compared, mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** verlet_particle_integrator: PASSED **");
      end else begin
         $display("** verlet_particle_integrator: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/vpi_pkg.sv
hdl/vpi_axis.sv
hdl/verlet_particle_integrator.sv
tb/sv/verlet_step_checker.sv
tb/sv/tb_verlet_particle_integrator.sv
